@@ src/go_back_n_sender_defines.svh @@
// Assertion macros shared by the go-back-n sender checker.
`ifndef GO_BACK_N_SENDER_DEFINES_SVH
`define GO_BACK_N_SENDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GNBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GNBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/gnbs_pkg.sv @@
// Types and constants shared by the go-back-n sender modules.
`default_nettype none

package gnbs_pkg;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int BYTE_W     = 8;
    localparam int WIN_W      = 4;
    localparam int TMO_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int SENT_SEQ_W = 4;
    localparam int WORD64_W   = 64;
    localparam int WORD32_W   = 32;

    // Largest window the 4-bit window register can name
    localparam int WIN_CFG_MAX = (1 << WIN_W) - 1;

    // Payload: 20 bytes, summed one 32-bit word per step
    localparam int PAY_BYTES   = 20;
    localparam int PAY_W       = PAY_BYTES * BYTE_W;
    localparam int CSUM_STEPS  = PAY_W / WORD32_W;
    localparam int CSUM_CNT_W  = $clog2(CSUM_STEPS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

    // Register reset values
    localparam logic [WIN_W-1:0] WIN_RESET = 4'd8;
    localparam logic [TMO_W-1:0] TMO_RESET = 16'd20;

    // Event codes
    localparam logic [OPCODE_W-1:0] OP_NEW  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ACK  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NEW     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   ack_seq_field;
        logic [BYTE_W-1:0]   ack_number;
        logic [BYTE_W-1:0]   ack_check;
        logic [WORD64_W-1:0] payload_word0;
        logic [WORD64_W-1:0] payload_word1;
        logic [WORD32_W-1:0] payload_word2;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SENT_SEQ_W-1:0] sent_seq;
        logic [BYTE_W-1:0]     sent_check;
        logic [WORD64_W-1:0]   out_word0;
        logic [WORD64_W-1:0]   out_word1;
        logic [WORD32_W-1:0]   out_word2;
        logic                  last;
    } result_t;

    // Request to the checksum unit
    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] init;
    } csum_req_t;

endpackage

`default_nettype wire

@@ src/go_back_n_sender.sv @@
// Go-back-N sender. New message: result loads after the shared checksum and push, and the
// next item is taken once the sender is idle again; refused: result loads at push.
// Ack: no result, next item once its checksum is done. Tick without expiry: next item the next cycle.
// Expiry resends each outstanding packet, oldest first, each through read, load, checksum
// and push; result stalls hold push. rst_n (async, active low) resets the window register and
// clears sequence, timer, handshake; the payload store is read only at slots written since.
`default_nettype none

module go_back_n_sender #(
    parameter int MAX_WINDOW = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input items
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire gnbs_pkg::item_t                   item,
    // results
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output gnbs_pkg::result_t                      result,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gnbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gnbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gnbs_pkg::*;

    // Effective window is bounded by both the store depth and the register range
    localparam int WIN_CAP = (MAX_WINDOW < WIN_CFG_MAX) ? MAX_WINDOW : WIN_CFG_MAX;
    localparam int SEQ_W   = $clog2(2 * WIN_CAP);
    localparam int CNT_W   = SEQ_W + 1;
    localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SUM    = 6'b000010,  // checksum of an outgoing packet in progress
        S_ACKSUM = 6'b000100,  // checksum of an arriving ack in progress
        S_READ   = 6'b001000,  // read one stored packet for resend
        S_LOAD   = 6'b010000,  // stored packet available, start its checksum
        S_PUSH   = 6'b100000   // hand the result to the output register
    } seq_state_t;

    seq_state_t state_reg, state_next;

    // Configuration and protocol state
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [TMO_W-1:0]  tmo_reg, tmo_next;
    logic [SEQ_W-1:0]  base_reg, base_next;
    logic [SEQ_W-1:0]  next_reg, next_next;
    logic [TMO_W-1:0]  tcnt_reg, tcnt_next;
    logic              trun_reg, trun_next;

    // Per-item working state
    logic [STATUS_W-1:0] kind_reg, kind_next;
    logic [SEQ_W-1:0]    rseq_reg, rseq_next;
    logic [SEQ_W-1:0]    left_reg, left_next;
    logic [BYTE_W-1:0]   ack_num_reg, ack_chk_reg;
    logic [PAY_W-1:0]    pay_reg;

    // Output register
    logic      out_valid_reg, out_valid_next;
    result_t   out_reg;

    // Payload store, one 160-bit row per window slot
    logic [PAY_W-1:0]  store_mem [MAX_WINDOW];
    logic [PAY_W-1:0]  rd_data_reg;

    // Derived window values
    logic [CNT_W-1:0]  w_eff, m_eff, outst, base_x, next_x, ack_x, ack_dist;
    logic [TMO_W-1:0]  tmo_eff;
    logic              win_full, ack_in_range, ack_good;
    logic [SLOT_W-1:0] wr_slot, rd_slot;
    logic [PAY_W-1:0]  item_pay;

    logic              item_accept, cfg_accept, out_load;
    csum_req_t         csum_req;
    logic [PAY_W-1:0]  csum_data;
    logic              csum_done;
    logic [BYTE_W-1:0] csum_sum;

    // Advance a sequence number around the space of size m
    function automatic logic [SEQ_W-1:0] seq_inc(input logic [CNT_W-1:0] x,
                                                 input logic [CNT_W-1:0] m);
        logic [CNT_W-1:0] y;
        begin
            y = x + 1'b1;
            seq_inc = (y == m) ? '0 : SEQ_W'(y);
        end
    endfunction

    // Slot of a sequence number: seq mod w, with seq below 2w
    function automatic logic [SLOT_W-1:0] seq_slot(input logic [CNT_W-1:0] x,
                                                   input logic [CNT_W-1:0] w);
        begin
            seq_slot = (x >= w) ? SLOT_W'(x - w) : SLOT_W'(x);
        end
    endfunction

    assign item_accept = item_valid && !item_stall;
    assign cfg_accept  = cfg_valid && cfg_ready;
    assign item_stall  = (state_reg != S_IDLE);
    // Configuration is to arrive only while the sender is quiet; the block does not enforce it
    assign cfg_ready   = 1'b1;

    // Window of zero acts as one; oversize acts as the store depth
    always_comb
    begin
        if (win_reg == '0)
            w_eff = CNT_W'(1);
        else if (32'(win_reg) > WIN_CAP)
            w_eff = CNT_W'(WIN_CAP);
        else
            w_eff = CNT_W'(win_reg);
    end

    assign m_eff   = w_eff << 1;
    assign tmo_eff = (tmo_reg == '0) ? TMO_W'(1) : tmo_reg;
    assign base_x  = CNT_W'(base_reg);
    assign next_x  = CNT_W'(next_reg);
    assign outst   = (next_x >= base_x) ? (next_x - base_x) : (next_x + m_eff - base_x);
    assign win_full = (outst >= w_eff);

    // Cumulative ack: must name a packet among the outstanding ones
    assign ack_in_range = (32'(ack_num_reg) < 32'(m_eff));
    assign ack_x        = CNT_W'(ack_num_reg);
    assign ack_dist     = (ack_x >= base_x) ? (ack_x - base_x) : (ack_x + m_eff - base_x);
    assign ack_good     = (csum_sum == ack_chk_reg) && ack_in_range && (ack_dist < outst);

    assign item_pay = {item.payload_word2, item.payload_word1, item.payload_word0};
    assign wr_slot  = seq_slot(next_x, w_eff);
    assign rd_slot  = seq_slot(CNT_W'(rseq_reg), w_eff);

    // Output register frees when empty or when its transaction completes
    assign out_load = (state_reg == S_PUSH) && (!out_valid_reg || !result_stall);

    // Checksum requests: new message at acceptance, ack at acceptance, resend on load
    always_comb
    begin
        csum_req.start = 1'b0;
        csum_req.init  = '0;
        csum_data      = item_pay;
        if (item_accept && (item.opcode == OP_NEW) && !win_full)
        begin
            csum_req.start = 1'b1;
            csum_req.init  = BYTE_W'(next_reg);
        end
        else if (item_accept && (item.opcode == OP_ACK))
        begin
            csum_req.start = 1'b1;
            csum_req.init  = item.ack_seq_field + item.ack_number;
        end
        else if (state_reg == S_LOAD)
        begin
            csum_req.start = 1'b1;
            csum_req.init  = BYTE_W'(rseq_reg);
            csum_data      = rd_data_reg;
        end
    end

    gnbs_csum u_csum (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (csum_req),
        .data  (csum_data),
        .done  (csum_done),
        .sum   (csum_sum)
    );

    // Sequencer and protocol state
    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        tmo_next   = tmo_reg;
        base_next  = base_reg;
        next_next  = next_reg;
        tcnt_next  = tcnt_reg;
        trun_next  = trun_reg;
        kind_next  = kind_reg;
        rseq_next  = rseq_reg;
        left_next  = left_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    unique case (item.opcode)
                        OP_NEW:
                        begin
                            if (win_full)
                            begin
                                // refuse: one result, no sequence number used
                                kind_next  = ST_REFUSED;
                                state_next = S_PUSH;
                            end
                            else
                            begin
                                kind_next  = ST_NEW;
                                rseq_next  = next_reg;
                                next_next  = seq_inc(next_x, m_eff);
                                if (outst == '0)
                                begin
                                    tcnt_next = tmo_eff;
                                    trun_next = 1'b1;
                                end
                                state_next = S_SUM;
                            end
                        end
                        OP_ACK:
                        begin
                            state_next = S_ACKSUM;
                        end
                        OP_TICK:
                        begin
                            if (trun_reg)
                            begin
                                if (tcnt_reg > TMO_W'(1))
                                    tcnt_next = tcnt_reg - 1'b1;
                                else
                                begin
                                    // expiry: reload and go back to the base
                                    tcnt_next = tmo_eff;
                                    kind_next = ST_RESENT;
                                    rseq_next = base_reg;
                                    left_next = SEQ_W'(outst);
                                    if (outst != '0)
                                        state_next = S_READ;
                                end
                            end
                        end
                        default:
                        begin
                            // unused event code: drop
                        end
                    endcase
                end
            end
            S_SUM:
            begin
                if (csum_done)
                    state_next = S_PUSH;
            end
            S_ACKSUM:
            begin
                if (csum_done)
                begin
                    if (ack_good)
                    begin
                        base_next = seq_inc(ack_x, m_eff);
                        if (seq_inc(ack_x, m_eff) == next_reg)
                        begin
                            trun_next = 1'b0;
                            tcnt_next = '0;
                        end
                        else
                        begin
                            trun_next = 1'b1;
                            tcnt_next = tmo_eff;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_SUM;
            end
            S_PUSH:
            begin
                if (out_load)
                begin
                    if ((kind_reg == ST_RESENT) && (left_reg != SEQ_W'(1)))
                    begin
                        // advance to the next outstanding packet
                        rseq_next  = seq_inc(CNT_W'(rseq_reg), m_eff);
                        left_next  = left_reg - 1'b1;
                        state_next = S_READ;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes: a new window empties it and stops the timer
        if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_WINDOW:
                begin
                    win_next  = WIN_W'(cfg_data);
                    base_next = '0;
                    next_next = '0;
                    trun_next = 1'b0;
                    tcnt_next = '0;
                end
                CFG_TIMEOUT:
                begin
                    tmo_next = TMO_W'(cfg_data);
                end
                default:
                begin
                    // unknown register: ignore
                end
            endcase
        end
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= WIN_RESET;
            tmo_reg       <= TMO_RESET;
            base_reg      <= '0;
            next_reg      <= '0;
            tcnt_reg      <= '0;
            trun_reg      <= 1'b0;
            kind_reg      <= ST_NEW;
            rseq_reg      <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            tmo_reg       <= tmo_next;
            base_reg      <= base_next;
            next_reg      <= next_next;
            tcnt_reg      <= tcnt_next;
            trun_reg      <= trun_next;
            kind_reg      <= kind_next;
            rseq_reg      <= rseq_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture the working payload and the ack fields
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            pay_reg     <= item_pay;
            ack_num_reg <= item.ack_number;
            ack_chk_reg <= item.ack_check;
        end
        else if (state_reg == S_LOAD)
            pay_reg <= rd_data_reg;
    end

    // Payload store: write a new packet at acceptance, read one row for resend
    always_ff @(posedge clk)
    begin
        if (item_accept && (item.opcode == OP_NEW) && !win_full)
            store_mem[wr_slot] <= item_pay;
        if (state_reg == S_READ)
            rd_data_reg <= store_mem[rd_slot];
    end

    // Result register; a refused message carries zeros
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.status <= kind_reg;
            out_reg.last   <= (kind_reg != ST_RESENT) || (left_reg == SEQ_W'(1));
            if (kind_reg == ST_REFUSED)
            begin
                out_reg.sent_seq   <= '0;
                out_reg.sent_check <= '0;
                out_reg.out_word0  <= '0;
                out_reg.out_word1  <= '0;
                out_reg.out_word2  <= '0;
            end
            else
            begin
                out_reg.sent_seq   <= SENT_SEQ_W'(rseq_reg);
                out_reg.sent_check <= csum_sum;
                out_reg.out_word0  <= pay_reg[WORD64_W-1:0];
                out_reg.out_word1  <= pay_reg[2*WORD64_W-1:WORD64_W];
                out_reg.out_word2  <= pay_reg[PAY_W-1:2*WORD64_W];
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

@@ src/gnbs_csum.sv @@
// Iterative 8-bit additive checksum unit: one 32-bit payload word per cycle.
`default_nettype none

module gnbs_csum (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire gnbs_pkg::csum_req_t      req,
    input  wire logic [gnbs_pkg::PAY_W-1:0] data,
    output logic                          done,
    output logic [gnbs_pkg::BYTE_W-1:0]   sum
);
    import gnbs_pkg::*;

    logic [BYTE_W-1:0]     acc_reg, acc_next;
    logic [PAY_W-1:0]      sh_reg, sh_next;
    logic [CSUM_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [BYTE_W-1:0]     step_sum;

    // Add the four bytes of the low word into the running sum
    assign step_sum = acc_reg + sh_reg[7:0] + sh_reg[15:8] + sh_reg[23:16] + sh_reg[31:24];

    always_comb
    begin
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next = req.init;
            sh_next  = data;
            cnt_next = CSUM_CNT_W'(CSUM_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            acc_next  = step_sum;
            sh_next   = sh_reg >> WORD32_W;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CSUM_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

`default_nettype wire

@@ src/gnbs_chk.sv @@
// Port-level assertions for the go-back-n sender, bound to its top level.
`default_nettype none

`include "go_back_n_sender_defines.svh"

module gnbs_chk (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            item_valid,
    input wire logic                            item_stall,
    input wire gnbs_pkg::item_t                 item,
    input wire logic                            result_valid,
    input wire logic                            result_stall,
    input wire gnbs_pkg::result_t               result
);
    import gnbs_pkg::*;

    // A stalled result holds until its transaction completes
    `GNBS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

    // A new message keeps the sender busy for at least the following cycle
    `GNBS_ASSERT_NEXT(a_new_busy, item_valid && !item_stall && (item.opcode == OP_NEW), item_stall, "sender ready right after a new message")

    // A refused message is a single all-zero result
    `GNBS_ASSERT_NOW(a_refused_zero, result_valid && (result.status == ST_REFUSED), result.last && (result.sent_seq == '0) && (result.sent_check == '0) && (result.out_word0 == '0), "refused result not zero")

    // A freshly sent packet is always the only result of its message
    `GNBS_ASSERT_NOW(a_new_last, result_valid && (result.status == ST_NEW), result.last, "new packet result without last")

    // Status carries one of the three defined codes
    `GNBS_ASSERT_NOW(a_status_code, result_valid, (result.status == ST_NEW) || (result.status == ST_RESENT) || (result.status == ST_REFUSED), "undefined result status")

endmodule

bind go_back_n_sender gnbs_chk u_gnbs_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

@@ tb/go_back_n_sender_test.sv @@
// Self-checking testbench for the go-back-N sender: directed cases, then random traffic.
module go_back_n_sender_test;
    import gnbs_pkg::*;

    localparam int SENDER_WINDOW = 8;
    // Opcode left unused by the block; it must be ignored.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    // Cycles to hold off after the last packet before a register write or the end:
    // covers an ack or a silent tick still in flight.
    localparam int QUIET_CYCLES = 24;

    logic clk = 1'b0;
    logic rst_n;

    logic                  item_valid;
    logic                  item_stall;
    item_t                 item_bus;
    logic                  result_valid;
    logic                  result_stall;
    result_t               packet_bus;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the sender: registers, window pointers, stored payloads, timer.
    logic [WIN_W-1:0] win_reg = WIN_RESET;
    logic [TMO_W-1:0] tmo_reg = TMO_RESET;
    int               base_seq = 0;
    int               next_seq = 0;
    logic [PAY_W-1:0] slot_payload [SENDER_WINDOW];
    logic [TMO_W-1:0] timer_left = '0;
    bit               timer_on = 1'b0;

    // Packets the sender owes us, oldest first.
    result_t expected_packets [$];
    int      mismatches = 0;

    // Upper bounds of the random idle draws on each side; zero turns idling off.
    int tx_gap_max = 14;
    int rx_stall_max = 14;

    go_back_n_sender #(.MAX_WINDOW(SENDER_WINDOW)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (packet_bus),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model of the sender
    // ------------------------------------------------------------------

    // Window as the block uses it: zero acts as one, large values clamp.
    function automatic int eff_window();
        if (win_reg == 0)
            return 1;
        if (win_reg > SENDER_WINDOW)
            return SENDER_WINDOW;
        return win_reg;
    endfunction

    // Packets sent but not yet acknowledged.
    function automatic int in_flight();
        int m;
        m = 2 * eff_window();
        return (next_seq + m - base_seq) % m;
    endfunction

    // 8-bit additive checksum over the seq byte, the ack byte and 20 payload bytes.
    function automatic logic [7:0] packet_sum(input logic [7:0] seq_b, input logic [7:0] ack_b,
                                              input logic [PAY_W-1:0] pay);
        logic [7:0] s;
        s = seq_b + ack_b;
        for (int i = 0; i < PAY_BYTES; i++)
            s = s + pay[i*8 +: 8];
        return s;
    endfunction

    function automatic result_t make_packet(input logic [STATUS_W-1:0] st,
                                            input logic [SENT_SEQ_W-1:0] seq,
                                            input logic [PAY_W-1:0] pay, input logic is_last);
        result_t r;
        r.status     = st;
        r.sent_seq   = seq;
        r.sent_check = packet_sum({4'b0000, seq}, 8'h00, pay);
        r.out_word0  = pay[63:0];
        r.out_word1  = pay[127:64];
        r.out_word2  = pay[159:128];
        r.last       = is_last;
        return r;
    endfunction

    // Reload the retransmission timer; a zero timeout acts as one tick.
    task automatic start_timer();
        timer_left = (tmo_reg == 0) ? 1 : tmo_reg;
        timer_on = 1'b1;
    endtask

    // Append a packet to the list of owed packets.
    task automatic owe_packet(input result_t p);
        expected_packets.insert(expected_packets.size(), p);
    endtask

    // Advance the shadow by one accepted event and queue the packets it causes.
    task automatic predict_packets(input item_t ev);
        int               w;
        int               m;
        int               busy;
        int               seq;
        int               ack_span;
        logic [PAY_W-1:0] pay;
        result_t          refused;
        w = eff_window();
        m = 2 * w;
        busy = in_flight();
        pay = {ev.payload_word2, ev.payload_word1, ev.payload_word0};
        case (ev.opcode)
            OP_NEW:
            begin
                if (busy >= w)
                begin
                    // Window full: refuse, consume no sequence number.
                    refused = '0;
                    refused.status = ST_REFUSED;
                    refused.last = 1'b1;
                    owe_packet(refused);
                end
                else
                begin
                    seq = next_seq;
                    slot_payload[seq % w] = pay;
                    if (busy == 0)
                        start_timer();
                    next_seq = (seq + 1) % m;
                    owe_packet(make_packet(ST_NEW, seq, pay, 1'b1));
                end
            end
            OP_ACK:
            begin
                // Drop acks with a bad checksum, out of the sequence space, or
                // naming nothing outstanding.
                if (packet_sum(ev.ack_seq_field, ev.ack_number, pay) == ev.ack_check &&
                    ev.ack_number < m)
                begin
                    ack_span = (ev.ack_number + m - base_seq) % m;
                    if (ack_span < busy)
                    begin
                        base_seq = (ev.ack_number + 1) % m;
                        if (base_seq == next_seq)
                        begin
                            timer_on = 1'b0;
                            timer_left = '0;
                        end
                        else
                            start_timer();
                    end
                end
            end
            OP_TICK:
            begin
                if (timer_on)
                begin
                    if (timer_left > 1)
                        timer_left = timer_left - 1;
                    else
                    begin
                        // Expiry: reload and resend every outstanding packet, oldest first.
                        start_timer();
                        for (int k = 0; k < busy && k < SENDER_WINDOW; k++)
                        begin
                            seq = (base_seq + k) % m;
                            owe_packet(make_packet(ST_RESENT, seq,
                                slot_payload[seq % w], k + 1 == busy));
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Event builders
    // ------------------------------------------------------------------

    // Random payload, now and then all zeros or all ones.
    function automatic logic [PAY_W-1:0] rand_payload();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Event with the given opcode and payload; the ack fields carry noise.
    function automatic item_t event_with(input logic [OPCODE_W-1:0] op,
                                         input logic [PAY_W-1:0] pay);
        item_t ev;
        ev.opcode        = op;
        ev.ack_seq_field = $urandom;
        ev.ack_number    = $urandom;
        ev.ack_check     = $urandom;
        ev.payload_word0 = pay[63:0];
        ev.payload_word1 = pay[127:64];
        ev.payload_word2 = pay[159:128];
        return ev;
    endfunction

    // Ack packet with a correct checksum for the given ack number.
    function automatic item_t good_ack(input logic [7:0] ackn);
        item_t ev;
        ev = event_with(OP_ACK, rand_payload());
        ev.ack_number = ackn;
        ev.ack_check = packet_sum(ev.ack_seq_field, ackn,
            {ev.payload_word2, ev.payload_word1, ev.payload_word0});
        return ev;
    endfunction

    // Mostly well-formed traffic: messages, ticks and acks that land in the window,
    // with some corrupt acks and unused opcodes mixed in.
    function automatic item_t random_event();
        int m;
        int busy;
        int r;
        int k;
        m = 2 * eff_window();
        busy = in_flight();
        r = $urandom_range(0, 99);
        if (r < 40)
            return event_with(OP_NEW, rand_payload());
        if (r < 65)
            return event_with(OP_TICK, rand_payload());
        if (r < 90)
        begin
            if ($urandom_range(0, 9) == 0)
                return good_ack($urandom);
            if (busy > 0 && $urandom_range(0, 7) != 0)
                k = $urandom_range(0, busy - 1);
            else
                k = $urandom_range(0, m - 1);
            return good_ack((base_seq + k) % m);
        end
        if (r < 98)
            return event_with(OP_ACK, rand_payload());
        return event_with(OP_UNUSED, rand_payload());
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Idle a random number of cycles, then present one event and hold it until
    // the sender takes it. Valid stays high after the transaction; the next call
    // either lowers it or replaces the payload at the following falling edge.
    task automatic send_event(input item_t ev);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        repeat (gap)
        begin
            @(negedge clk);
            item_valid = 1'b0;
        end
        @(negedge clk);
        item_bus = ev;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        predict_packets(ev);
    endtask

    // Drop valid, wait for every owed packet, then let any silent work finish.
    task automatic settle();
        @(negedge clk);
        item_valid = 1'b0;
        while (expected_packets.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES)
            @(posedge clk);
    endtask

    // Write one register once the sender is idle, and mirror it in the shadow.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        settle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_WINDOW)
        begin
            // A window write empties the window and stops the timer.
            win_reg = data[WIN_W-1:0];
            base_seq = 0;
            next_seq = 0;
            timer_on = 1'b0;
            timer_left = '0;
        end
        else if (idx == CFG_TIMEOUT)
            tmo_reg = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Window value with noise in the bits above the register width.
    function automatic logic [CFG_DATA_W-1:0] window_word(input int w);
        logic [CFG_DATA_W-1:0] d;
        d = $urandom;
        d[WIN_W-1:0] = w;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset window of 8: fill it with extreme and random payloads, then get refused.
    task automatic test_fill_window();
        send_event(event_with(OP_NEW, '0));
        send_event(event_with(OP_NEW, '1));
        repeat (6)
            send_event(event_with(OP_NEW, rand_payload()));
        send_event(event_with(OP_NEW, rand_payload()));
    endtask

    // Acks that must be dropped, the unused opcode, then one cumulative ack.
    task automatic test_ack_filtering();
        item_t ev;
        ev = good_ack(8'd2);
        ev.ack_check = ev.ack_check ^ 8'h01;
        send_event(ev);
        send_event(good_ack(8'hFF));
        send_event(good_ack(8'd8));
        send_event(event_with(OP_UNUSED, rand_payload()));
        send_event(good_ack(8'd2));
    endtask

    // Window of 3 with a zero timeout: every running tick expires and resends.
    task automatic test_timer_expiry();
        write_register(CFG_WINDOW, window_word(3));
        write_register(CFG_TIMEOUT, '0);
        repeat (4)
            send_event(event_with(OP_NEW, rand_payload()));
        send_event(event_with(OP_TICK, rand_payload()));
        send_event(good_ack(8'd0));
        send_event(event_with(OP_TICK, rand_payload()));
        send_event(good_ack(8'd2));
        // Timer is stopped now: this tick must stay silent.
        send_event(event_with(OP_TICK, rand_payload()));
    endtask

    // A window register of zero behaves as a window of one.
    task automatic test_tiny_window();
        write_register(CFG_WINDOW, window_word(0));
        send_event(event_with(OP_NEW, rand_payload()));
        send_event(event_with(OP_NEW, rand_payload()));
        send_event(event_with(OP_TICK, rand_payload()));
    endtask

    // Random traffic over a series of settings; some phases run with no idling.
    task automatic test_random_traffic();
        int phase_win [10]   = '{15, 1, 2, 5, 8, 4, 6, 12, 3, 7};
        int phase_tmo [10]   = '{3, 1, 2, 4, 65535, 1, 5, 2, 7, 3};
        int phase_items [10] = '{40, 30, 35, 40, 25, 40, 35, 40, 40, 35};
        int phase_gap [10]   = '{14, 14, 0, 14, 14, 0, 14, 14, 3, 14};
        int phase_stall [10] = '{14, 14, 0, 0, 14, 14, 14, 5, 14, 14};
        int sent;
        item_t ev;
        for (int p = 0; p < 10; p++)
        begin
            write_register(CFG_WINDOW, window_word(phase_win[p]));
            write_register(CFG_TIMEOUT, phase_tmo[p]);
            tx_gap_max = phase_gap[p];
            rx_stall_max = phase_stall[p];
            sent = 0;
            while (sent < phase_items[p])
            begin
                ev = random_event();
                send_event(ev);
                if (ev.opcode != OP_UNUSED)
                    sent++;
            end
        end
        tx_gap_max = 14;
        rx_stall_max = 14;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall for a random number of cycles before each packet, then take it.
    initial
    begin
        int n;
        result_stall = 1'b0;
        forever
        begin
            n = $urandom_range(0, rx_stall_max);
            repeat (n)
            begin
                @(negedge clk);
                result_stall = 1'b1;
            end
            @(negedge clk);
            result_stall = 1'b0;
            do
                @(posedge clk);
            while (!(rst_n && result_valid && !result_stall));
        end
    end

    // Compare every packet transaction with the oldest owed packet.
    always @(posedge clk)
    begin : check_packets
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_packets.size() == 0)
            begin
                $error("unexpected packet: status %0d seq %0d",
                       packet_bus.status, packet_bus.sent_seq);
                mismatches++;
            end
            else
            begin
                want = expected_packets[0];
                expected_packets.delete(0);
                if (packet_bus.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, packet_bus.status);
                    mismatches++;
                end
                if (packet_bus.sent_seq !== want.sent_seq)
                begin
                    $error("sent_seq: expected %0d, got %0d",
                           want.sent_seq, packet_bus.sent_seq);
                    mismatches++;
                end
                if (packet_bus.sent_check !== want.sent_check)
                begin
                    $error("sent_check: expected %0h, got %0h",
                           want.sent_check, packet_bus.sent_check);
                    mismatches++;
                end
                if (packet_bus.out_word0 !== want.out_word0)
                begin
                    $error("out_word0: expected %0h, got %0h",
                           want.out_word0, packet_bus.out_word0);
                    mismatches++;
                end
                if (packet_bus.out_word1 !== want.out_word1)
                begin
                    $error("out_word1: expected %0h, got %0h",
                           want.out_word1, packet_bus.out_word1);
                    mismatches++;
                end
                if (packet_bus.out_word2 !== want.out_word2)
                begin
                    $error("out_word2: expected %0h, got %0h",
                           want.out_word2, packet_bus.out_word2);
                    mismatches++;
                end
                if (packet_bus.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, packet_bus.last);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_bus = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WINDOW;
        cfg_data = '0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fill_window();
        test_ack_filtering();
        test_timer_expiry();
        test_tiny_window();
        test_random_traffic();
        settle();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: give up on a hung handshake.
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/gnbs_pkg.sv
src/gnbs_csum.sv
src/go_back_n_sender.sv
src/gnbs_chk.sv
tb/go_back_n_sender_test.sv
